// ----- rtl/midi_track_event_parser_assert.svh -----
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define MTEP_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define MTEP_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mtep_pkg.sv -----
package mtep_pkg;

  // Parser phase within the track byte stream
  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_STATUS   = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SYSLEN   = 4'd4,
    PH_METATYPE = 4'd5,
    PH_METALEN  = 4'd6,
    PH_SYSSKIP  = 4'd7,
    PH_METABODY = 4'd8,
    PH_ENDED    = 4'd9
  } phase_t;

  // Reported event kinds
  typedef enum logic [2:0] {
    EV_NOTE_OFF   = 3'd0,
    EV_NOTE_ON    = 3'd1,
    EV_AFTERTOUCH = 3'd2,
    EV_CONTROL    = 3'd3,
    EV_PROGRAM    = 3'd4,
    EV_TEMPO      = 3'd5,
    EV_END        = 3'd6,
    EV_BAD        = 3'd7
  } kind_t;

  // Channel message high nibbles
  localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
  localparam logic [3:0] MSG_AFTERTOUCH = 4'hA;
  localparam logic [3:0] MSG_CONTROL    = 4'hB;
  localparam logic [3:0] MSG_PROGRAM    = 4'hC;
  localparam logic [3:0] MSG_PRESSURE   = 4'hD;
  localparam logic [3:0] MSG_SYSTEM     = 4'hF;

  // System and meta codes
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_ESC   = 8'hF7;
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] META_END    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  localparam int unsigned TEMPO_W   = 24;
  localparam int unsigned TICK_W    = 32;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd500000;

  // Result packing widths
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned OUT_USED_W = 108;

endpackage

// ----- rtl/midi_track_event_parser.sv -----
// MIDI track event parser. Feed the body bytes of a track chunk on the slave
// stream, one byte per request, with tuser set on the first byte of each track;
// that byte clears the tick sum, running status and parse phase (tempo is kept).
// A byte is taken every cycle while the result register is free or being
// drained. The byte is held in the input register and is decoded into the
// result register once that register is free or being drained; the result
// register drives the master side. Input ready drops only while a
// result is held by a stalled master side. Most bytes produce no result; note
// off (including note on with velocity zero), note on, aftertouch, control
// change, program change, set tempo, end of track and bad status each produce
// one. Master tuser carries the event kind; tdata carries, from bit 0 up,
// channel, first data, second data, delta ticks, absolute tick and current
// tempo. Writing cfg_wr_data loads the current tempo at once; write it only
// while the parser is idle.
module midi_track_event_parser
  import mtep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]            s_axis_tuser,   // [0] track_start
  // Master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] channel, [11:4] first_data,
                                                // [19:12] second_data,
                                                // [51:20] delta_ticks,
                                                // [83:52] absolute_tick,
                                                // [107:84] tempo_now, rest zero
  output logic [2:0]            m_axis_tuser,   // [2:0] event_kind
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [TEMPO_W-1:0]    cfg_wr_data     // initial_tempo
);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;

  // Parser state
  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   length_accumulator, length_accumulator_next;
  logic [TICK_W-1:0]   delta_hold, delta_hold_next;
  logic [7:0]          running_status, running_status_next;
  logic [7:0]          active_status, active_status_next;
  logic [7:0]          first_data_hold, first_data_hold_next;
  logic [7:0]          meta_kind, meta_kind_next;
  logic [TICK_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [TICK_W-1:0]   tick_sum, tick_sum_next;
  logic [TEMPO_W-1:0]  tempo_value, tempo_value_next;

  // Per-byte working values
  phase_t              ph_eff;
  logic [TICK_W-1:0]   acc_eff;
  logic [TICK_W-1:0]   rem_eff;
  logic [TICK_W-1:0]   tick_eff;
  logic [7:0]          rs_eff;
  logic [7:0]          as_eff;
  logic [TICK_W-1:0]   acc_vlq;
  logic [TEMPO_W-1:0]  acc_body;
  logic [TICK_W-1:0]   rem_dec;
  logic [3:0]          msg_kind;
  logic                meta_finish;
  logic [TEMPO_W-1:0]  meta_acc;

  // Event produced by this byte
  logic                emit;
  kind_t               ev_kind;
  logic [3:0]          ev_chan;
  logic [7:0]          ev_d1;
  logic [7:0]          ev_d2;

  // Move the held byte on when the result register is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Capture the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  // Apply the track start clear, then decode the byte by phase
  always_comb begin
    ph_eff   = in_start ? PH_DELTA : phase;
    acc_eff  = in_start ? '0 : length_accumulator;
    rem_eff  = in_start ? '0 : bytes_remaining;
    tick_eff = in_start ? '0 : tick_sum;
    rs_eff   = in_start ? '0 : running_status;
    as_eff   = in_start ? '0 : active_status;

    acc_vlq  = {acc_eff[TICK_W-8:0], in_byte[6:0]};
    acc_body = {acc_eff[TEMPO_W-9:0], in_byte};
    rem_dec  = rem_eff - TICK_W'(1);
    msg_kind = as_eff[7:4];

    phase_next              = ph_eff;
    length_accumulator_next = acc_eff;
    delta_hold_next         = delta_hold;
    running_status_next     = rs_eff;
    active_status_next      = as_eff;
    first_data_hold_next    = first_data_hold;
    meta_kind_next          = meta_kind;
    bytes_remaining_next    = rem_eff;
    tick_sum_next           = tick_eff;
    tempo_value_next        = tempo_value;

    meta_finish = 1'b0;
    meta_acc    = '0;
    emit        = 1'b0;
    ev_kind     = EV_BAD;
    ev_chan     = '0;
    ev_d1       = '0;
    ev_d2       = '0;

    case (ph_eff)
      PH_DELTA: begin
        if (!in_byte[7]) begin
          delta_hold_next         = acc_vlq;
          tick_sum_next           = tick_eff + acc_vlq;
          length_accumulator_next = '0;
          phase_next              = PH_STATUS;
        end else begin
          length_accumulator_next = acc_vlq;
        end
      end

      PH_STATUS: begin
        if (!in_byte[7]) begin
          if (rs_eff == '0) begin
            // Report the stray byte, then take it as a one-byte delta
            emit                    = 1'b1;
            ev_kind                 = EV_BAD;
            ev_d1                   = in_byte;
            delta_hold_next         = acc_vlq;
            tick_sum_next           = tick_eff + acc_vlq;
            length_accumulator_next = '0;
            phase_next              = PH_STATUS;
          end else begin
            // Running status: this is the first data byte
            active_status_next = rs_eff;
            if (rs_eff[7:4] == MSG_PROGRAM) begin
              emit       = 1'b1;
              ev_kind    = EV_PROGRAM;
              ev_chan    = rs_eff[3:0];
              ev_d1      = in_byte;
              phase_next = PH_DELTA;
            end else if (rs_eff[7:4] == MSG_PRESSURE) begin
              phase_next = PH_DELTA;
            end else begin
              first_data_hold_next = in_byte;
              phase_next           = PH_DATA2;
            end
          end
        end else begin
          active_status_next = in_byte;
          if (in_byte[7:4] != MSG_SYSTEM) begin
            running_status_next = in_byte;
            phase_next          = PH_DATA1;
          end else begin
            running_status_next     = '0;
            length_accumulator_next = '0;
            if (in_byte == SYSEX_START || in_byte == SYSEX_ESC) begin
              phase_next = PH_SYSLEN;
            end else if (in_byte == META_STATUS) begin
              phase_next = PH_METATYPE;
            end else begin
              phase_next = PH_DELTA;
            end
          end
        end
      end

      PH_DATA1: begin
        if (msg_kind == MSG_PROGRAM) begin
          emit       = 1'b1;
          ev_kind    = EV_PROGRAM;
          ev_chan    = as_eff[3:0];
          ev_d1      = in_byte;
          phase_next = PH_DELTA;
        end else if (msg_kind == MSG_PRESSURE) begin
          phase_next = PH_DELTA;
        end else begin
          first_data_hold_next = in_byte;
          phase_next           = PH_DATA2;
        end
      end

      PH_DATA2: begin
        phase_next = PH_DELTA;
        ev_chan    = as_eff[3:0];
        ev_d1      = first_data_hold;
        ev_d2      = in_byte;
        case (msg_kind)
          MSG_NOTE_OFF: begin
            emit    = 1'b1;
            ev_kind = EV_NOTE_OFF;
          end
          MSG_NOTE_ON: begin
            emit    = 1'b1;
            ev_kind = (in_byte != '0) ? EV_NOTE_ON : EV_NOTE_OFF;
          end
          MSG_AFTERTOUCH: begin
            emit    = 1'b1;
            ev_kind = EV_AFTERTOUCH;
          end
          MSG_CONTROL: begin
            emit    = 1'b1;
            ev_kind = EV_CONTROL;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end

      PH_SYSLEN: begin
        if (!in_byte[7]) begin
          bytes_remaining_next    = acc_vlq;
          length_accumulator_next = '0;
          phase_next              = (acc_vlq != '0) ? PH_SYSSKIP : PH_DELTA;
        end else begin
          length_accumulator_next = acc_vlq;
        end
      end

      PH_SYSSKIP: begin
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_DELTA;
        end
      end

      PH_METATYPE: begin
        meta_kind_next          = in_byte;
        length_accumulator_next = '0;
        phase_next              = PH_METALEN;
      end

      PH_METALEN: begin
        if (!in_byte[7]) begin
          bytes_remaining_next    = acc_vlq;
          length_accumulator_next = '0;
          if (acc_vlq == '0) begin
            meta_finish = 1'b1;
          end else begin
            phase_next = PH_METABODY;
          end
        end else begin
          length_accumulator_next = acc_vlq;
        end
      end

      PH_METABODY: begin
        length_accumulator_next = {{(TICK_W-TEMPO_W){1'b0}}, acc_body};
        bytes_remaining_next    = rem_dec;
        if (rem_dec == '0) begin
          meta_finish = 1'b1;
          meta_acc    = acc_body;
        end
      end

      default: begin
        phase_next = ph_eff;
      end
    endcase

    // Close a meta event at the end of its body
    if (meta_finish) begin
      length_accumulator_next = '0;
      if (meta_kind == META_TEMPO) begin
        tempo_value_next = meta_acc;
        phase_next       = PH_DELTA;
        emit             = 1'b1;
        ev_kind          = EV_TEMPO;
      end else if (meta_kind == META_END) begin
        phase_next = PH_ENDED;
        emit       = 1'b1;
        ev_kind    = EV_END;
      end else begin
        phase_next = PH_DELTA;
      end
    end
  end

  // Advance the parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_DELTA;
      length_accumulator <= '0;
      delta_hold         <= '0;
      running_status     <= '0;
      active_status      <= '0;
      first_data_hold    <= '0;
      meta_kind          <= '0;
      bytes_remaining    <= '0;
      tick_sum           <= '0;
      tempo_value        <= TEMPO_RESET;
    end else begin
      if (advance) begin
        phase              <= phase_next;
        length_accumulator <= length_accumulator_next;
        delta_hold         <= delta_hold_next;
        running_status     <= running_status_next;
        active_status      <= active_status_next;
        first_data_hold    <= first_data_hold_next;
        meta_kind          <= meta_kind_next;
        bytes_remaining    <= bytes_remaining_next;
        tick_sum           <= tick_sum_next;
      end
      // Configuration write loads the tempo directly
      if (cfg_wr_en) begin
        tempo_value <= cfg_wr_data;
      end else if (advance) begin
        tempo_value <= tempo_value_next;
      end
    end
  end

  // Hold the result until the master side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (advance && emit) begin
      m_axis_tuser <= ev_kind;
      m_axis_tdata <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, tempo_value_next, tick_sum,
                       delta_hold, ev_d2, ev_d1, ev_chan};
    end
  end

endmodule

// ----- rtl/mtep_checker.sv -----
`include "midi_track_event_parser_assert.svh"

module mtep_checker
  import mtep_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]            m_axis_tuser
);

  logic is_meta_kind;
  logic is_note_on;
  logic is_program;

  assign is_meta_kind = m_axis_tvalid && (m_axis_tuser == EV_TEMPO ||
                        m_axis_tuser == EV_END || m_axis_tuser == EV_BAD);
  assign is_note_on   = m_axis_tvalid && (m_axis_tuser == EV_NOTE_ON);
  assign is_program   = m_axis_tvalid && (m_axis_tuser == EV_PROGRAM);

  // A stalled result keeps its contents
  `MTEP_ASSERT_NEXT(a_hold_stalled, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // Tempo, end of track and bad status carry no channel and no second byte
  `MTEP_ASSERT_SAME(a_meta_fields, clk, rst, is_meta_kind, m_axis_tdata[3:0] == '0 && m_axis_tdata[19:12] == '0, "meta-class event with channel or second data")

  // Note on always has a nonzero velocity
  `MTEP_ASSERT_SAME(a_note_on_vel, clk, rst, is_note_on, m_axis_tdata[19:12] != '0, "note on with zero velocity")

  // Program change has no second byte
  `MTEP_ASSERT_SAME(a_program_d2, clk, rst, is_program, m_axis_tdata[19:12] == '0, "program change with second data")

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
